[hw/rtl/qbps_pkg.sv]
// Types, constants and FSM states shared by the quota burst path scheduler.
// No dependencies.
package qbps_pkg;

  localparam int MASK_W  = 8;
  localparam int PATH_W  = 5;
  localparam int QUOTA_W = 8;
  localparam int LEN_W   = 16;
  localparam int LIMIT_W = 24;

  typedef struct packed {
    logic              kind;
    logic [MASK_W-1:0] loose_avail_mask;
    logic [MASK_W-1:0] strict_avail_mask;
    logic [MASK_W-1:0] sent_mask;
    logic              fin_answer;
    logic [2:0]        fin_path;
    logic [LEN_W-1:0]  seg_len;
    logic [LEN_W-1:0]  mss;
  } in_item_t;

  typedef struct packed {
    logic               found;
    logic [2:0]         path;
    logic [LIMIT_W-1:0] limit_bytes;
    logic               clear_sent;
  } out_item_t;

  // Scan token carried from cell to cell.
  typedef struct packed {
    logic [QUOTA_W-1:0] best_room;
    logic               best_found;
    logic [PATH_W-1:0]  best_idx;
    logic               elig_any;
    logic               all_full;
    logic               rbest_found;
    logic [PATH_W-1:0]  rbest_idx;
    logic               rbak_found;
    logic [PATH_W-1:0]  rbak_idx;
  } scan_t;

  // Broadcast from the controller to every cell.
  typedef struct packed {
    logic [QUOTA_W-1:0] burst;
    logic               clear;
    logic               grow;
    logic [PATH_W-1:0]  grow_idx;
    logic [QUOTA_W-1:0] grow_amt;
  } cell_cmd_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_START,
    ST_SCAN,
    ST_CLEAR,
    ST_CHECK,
    ST_GROW,
    ST_OUT
  } state_t;

endpackage

[hw/rtl/quota_burst_path_scheduler.sv]
// After accept, a reinject or no eligible path goes from the scan straight to output,
// a pick that fails the strict test passes the check first, and a granted segment also
// waits for the 16-step divider started at accept. A quota refill clears and repeats the
// scan. A new item is accepted only after the result has been loaded into the output
// register. Reset: all path quotas zero, burst_segments 1, both channels empty.
// Top level; depends on qbps_pkg, qbps_cell and qbps_div.
module quota_burst_path_scheduler #(
  parameter int NUM_PATHS = 8
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  qbps_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output qbps_pkg::out_item_t out_data,
  input  logic                cfg_wr_en,
  input  logic [7:0]          cfg_wr_data
);
  import qbps_pkg::*;

  state_t             state_r, state_nxt;
  in_item_t           in_r;
  logic [QUOTA_W-1:0] burst_r;
  logic               retried_r, retried_nxt;
  logic [PATH_W-1:0]  pick_r, pick_nxt;
  logic [QUOTA_W-1:0] room_r, room_nxt;
  out_item_t          res_r, res_nxt;
  logic               out_valid_r, out_valid_nxt;
  out_item_t          out_r, out_nxt;
  logic               tok_start, div_start, div_done;
  logic [QUOTA_W-1:0] grow_amt;
  cell_cmd_t          cmd;
  logic               in_accept;
  logic               fin_ok;

  logic  chain_v [NUM_PATHS+1];
  scan_t chain_c [NUM_PATHS+1];
  logic  loose_bits  [NUM_PATHS];
  logic  strict_bits [NUM_PATHS];
  logic  sent_bits   [NUM_PATHS];
  scan_t scan_res;

  assign in_stall  = (state_r != ST_IDLE);
  assign in_accept = in_valid && !in_stall;

  assign chain_v[0] = tok_start;
  always_comb begin
    chain_c[0]          = '0;
    chain_c[0].all_full = 1'b1;
  end
  assign scan_res = chain_c[NUM_PATHS];

  genvar gi;
  generate
    for (gi = 0; gi < NUM_PATHS; gi++) begin : g_cell
      if (gi < MASK_W) begin : g_bits
        assign loose_bits[gi]  = in_r.loose_avail_mask[gi];
        assign strict_bits[gi] = in_r.strict_avail_mask[gi];
        assign sent_bits[gi]   = in_r.sent_mask[gi];
      end else begin : g_nobits
        assign loose_bits[gi]  = 1'b0;
        assign strict_bits[gi] = 1'b0;
        assign sent_bits[gi]   = 1'b0;
      end
      qbps_cell #(.CELL_IDX(gi)) u_cell (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .loose_bit    (loose_bits[gi]),
        .strict_bit   (strict_bits[gi]),
        .sent_bit     (sent_bits[gi]),
        .tok_valid_in (chain_v[gi]),
        .tok_in       (chain_c[gi]),
        .tok_valid_out(chain_v[gi+1]),
        .tok_out      (chain_c[gi+1])
      );
    end
  endgenerate

  qbps_div u_div (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (div_start),
    .seg_len(in_data.seg_len),
    .mss    (in_data.mss),
    .done   (div_done),
    .grow   (grow_amt)
  );

  assign fin_ok = in_r.fin_answer && (32'(in_r.fin_path) < NUM_PATHS) &&
                  in_r.strict_avail_mask[in_r.fin_path];

  always_comb begin
    state_nxt     = state_r;
    retried_nxt   = retried_r;
    pick_nxt      = pick_r;
    room_nxt      = room_r;
    res_nxt       = res_r;
    out_valid_nxt = out_valid_r;
    out_nxt       = out_r;
    tok_start     = 1'b0;
    div_start     = 1'b0;
    cmd           = '0;
    cmd.burst     = burst_r;
    cmd.grow_idx  = pick_r;
    cmd.grow_amt  = grow_amt;

    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      ST_IDLE: begin
        if (in_accept) begin
          div_start   = 1'b1;
          retried_nxt = 1'b0;
          state_nxt   = ST_START;
        end
      end
      ST_START: begin
        tok_start = 1'b1;
        state_nxt = ST_SCAN;
      end
      ST_SCAN: begin
        if (chain_v[NUM_PATHS]) begin
          res_nxt = '0;
          if (in_r.kind) begin
            if (fin_ok) begin
              res_nxt.found = 1'b1;
              res_nxt.path  = in_r.fin_path;
            end else if (scan_res.rbest_found) begin
              res_nxt.found = 1'b1;
              res_nxt.path  = scan_res.rbest_idx[2:0];
            end else if (scan_res.rbak_found) begin
              res_nxt.found      = 1'b1;
              res_nxt.path       = scan_res.rbak_idx[2:0];
              res_nxt.clear_sent = 1'b1;
            end
            state_nxt = ST_OUT;
          end else if (scan_res.best_found) begin
            pick_nxt  = scan_res.best_idx;
            room_nxt  = scan_res.best_room;
            state_nxt = ST_CHECK;
          end else if (scan_res.elig_any && scan_res.all_full && !retried_r) begin
            state_nxt = ST_CLEAR;
          end else begin
            state_nxt = ST_OUT;
          end
        end
      end
      ST_CLEAR: begin
        cmd.clear   = 1'b1;
        retried_nxt = 1'b1;
        state_nxt   = ST_START;
      end
      ST_CHECK: begin
        res_nxt = '0;
        if (in_r.strict_avail_mask[pick_r[2:0]]) begin
          res_nxt.found       = 1'b1;
          res_nxt.path        = pick_r[2:0];
          res_nxt.limit_bytes = LIMIT_W'(room_r) * LIMIT_W'(in_r.mss);
          state_nxt           = ST_GROW;
        end else begin
          state_nxt = ST_OUT;
        end
      end
      ST_GROW: begin
        if (div_done) begin
          cmd.grow  = 1'b1;
          state_nxt = ST_OUT;
        end
      end
      ST_OUT: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          out_nxt       = res_r;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      retried_r   <= 1'b0;
      burst_r     <= 8'd1;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      retried_r   <= retried_nxt;
      if (cfg_wr_en) begin
        burst_r <= cfg_wr_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      in_r <= in_data;
    end
    pick_r <= pick_nxt;
    room_r <= room_nxt;
    res_r  <= res_nxt;
    out_r  <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  a_none_is_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_r.found |->
      out_r.path == '0 && out_r.limit_bytes == '0 && !out_r.clear_sent)
    else $error("empty result carries nonzero fields");

  a_backup_no_limit: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_r.clear_sent |-> out_r.found && out_r.limit_bytes == '0)
    else $error("backup result with byte limit");

  a_clear_rescans: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_CLEAR |=> state_r == ST_START && retried_r)
    else $error("quota refill not followed by rescan");

  a_grow_once: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_GROW && div_done |=> state_r == ST_OUT)
    else $error("quota growth did not complete");

  a_scan_owned: assert property (@(posedge clk) disable iff (!rst_n)
    chain_v[NUM_PATHS] |-> state_r == ST_SCAN)
    else $error("scan token finished outside scan");

endmodule

[hw/rtl/qbps_cell.sv]
// One path cell: holds that path's burst quota and updates the scan token.
// Depends on qbps_pkg.
module qbps_cell #(
  parameter int CELL_IDX = 0
) (
  input  logic              clk,
  input  logic              rst_n,
  input  qbps_pkg::cell_cmd_t cmd,
  input  logic              loose_bit,
  input  logic              strict_bit,
  input  logic              sent_bit,
  input  logic              tok_valid_in,
  input  qbps_pkg::scan_t   tok_in,
  output logic              tok_valid_out,
  output qbps_pkg::scan_t   tok_out
);
  import qbps_pkg::*;

  logic [QUOTA_W-1:0] quota_r, quota_nxt;
  logic               tok_valid_r;
  scan_t              tok_r, tok_nxt;
  logic               enabled, elig;
  logic [QUOTA_W-1:0] room;
  logic [QUOTA_W:0]   sum;

  assign enabled = (cmd.burst != '0);
  assign elig    = loose_bit && enabled;
  assign room    = cmd.burst - quota_r;
  assign sum     = {1'b0, quota_r} + {1'b0, cmd.grow_amt};

  always_comb begin
    tok_nxt = tok_in;
    tok_nxt.elig_any = tok_in.elig_any | elig;
    tok_nxt.all_full = tok_in.all_full & (!elig || (quota_r >= cmd.burst));
    if (elig && (quota_r < cmd.burst) && (room > tok_in.best_room)) begin
      tok_nxt.best_room  = room;
      tok_nxt.best_found = 1'b1;
      tok_nxt.best_idx   = PATH_W'(CELL_IDX);
    end
    if (enabled && strict_bit) begin
      if (sent_bit) begin
        tok_nxt.rbak_found = 1'b1;
        tok_nxt.rbak_idx   = PATH_W'(CELL_IDX);
      end else begin
        tok_nxt.rbest_found = 1'b1;
        tok_nxt.rbest_idx   = PATH_W'(CELL_IDX);
      end
    end
  end

  always_comb begin
    quota_nxt = quota_r;
    if (cmd.clear && loose_bit) begin
      quota_nxt = '0;
    end else if (cmd.grow && (cmd.grow_idx == PATH_W'(CELL_IDX))) begin
      quota_nxt = sum[QUOTA_W] ? '1 : sum[QUOTA_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      quota_r     <= '0;
      tok_valid_r <= 1'b0;
    end else begin
      quota_r     <= quota_nxt;
      tok_valid_r <= tok_valid_in;
    end
  end

  always_ff @(posedge clk) begin
    if (tok_valid_in) begin
      tok_r <= tok_nxt;
    end
  end

  assign tok_valid_out = tok_valid_r;
  assign tok_out       = tok_r;

endmodule

[hw/rtl/qbps_div.sv]
// Bit-serial divider: quota growth ceil(len/mss), floored at 1, saturated at 255.
// Depends on qbps_pkg.
module qbps_div (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [qbps_pkg::LEN_W-1:0] seg_len,
  input  logic [qbps_pkg::LEN_W-1:0] mss,
  output logic                       done,
  output logic [qbps_pkg::QUOTA_W-1:0] grow
);
  import qbps_pkg::*;

  localparam int CNT_W = $clog2(LEN_W);

  logic             busy_r, busy_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [LEN_W:0]   rem_r, rem_nxt;
  logic [LEN_W-1:0] quo_r, quo_nxt;
  logic [LEN_W-1:0] den_r, den_nxt;
  logic             gt_r, gt_nxt;
  logic [LEN_W-1:0] den_in;
  logic [LEN_W:0]   rem_sh;
  logic [LEN_W:0]   ceil_q;

  assign den_in = (mss == '0) ? LEN_W'(1) : mss;
  assign rem_sh = {rem_r[LEN_W-1:0], quo_r[LEN_W-1]};
  assign ceil_q = {1'b0, quo_r} + {{LEN_W{1'b0}}, (rem_r != '0)};

  always_comb begin
    busy_nxt = busy_r;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    den_nxt  = den_r;
    gt_nxt   = gt_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      rem_nxt  = '0;
      quo_nxt  = seg_len;
      den_nxt  = den_in;
      gt_nxt   = (seg_len > den_in);
    end else if (busy_r) begin
      if (rem_sh >= {1'b0, den_r}) begin
        rem_nxt = rem_sh - {1'b0, den_r};
        quo_nxt = {quo_r[LEN_W-2:0], 1'b1};
      end else begin
        rem_nxt = rem_sh;
        quo_nxt = {quo_r[LEN_W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == CNT_W'(LEN_W - 1)) begin
        busy_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    den_r <= den_nxt;
    gt_r  <= gt_nxt;
  end

  assign done = !busy_r;
  assign grow = !gt_r ? QUOTA_W'(1) :
                (ceil_q[LEN_W:QUOTA_W] != '0) ? '1 : ceil_q[QUOTA_W-1:0];

endmodule
